@@ rtl/sof_len_xor_eof_deframer_unit_defines.svh @@
`ifndef SOF_LEN_XOR_EOF_DEFRAMER_UNIT_DEFINES_SVH
`define SOF_LEN_XOR_EOF_DEFRAMER_UNIT_DEFINES_SVH

// concurrent check, quiet while reset is held
`define SOFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check, live through reset
`define SOFD_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/sofd_pkg.sv @@
package sofd_pkg;

  localparam int unsigned MAX_PAYLOAD = 128;

  localparam logic [7:0] START_BYTE_RST    = 8'hAA;
  localparam logic [7:0] END_BYTE_RST      = 8'h55;
  localparam logic [7:0] PAYLOAD_LIMIT_RST = 8'd128;
  localparam logic [7:0] MAX_PAYLOAD_B     = 8'(MAX_PAYLOAD);

  localparam int unsigned OUT_TDATA_W = 40;

  typedef enum logic [1:0] {
    REG_START_BYTE    = 2'd0,
    REG_END_BYTE      = 2'd1,
    REG_PAYLOAD_LIMIT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_XOR_BAD = 2'd1,
    ST_END_BAD = 2'd2,
    ST_LEN_BAD = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LEN  = 3'd1,
    PH_BODY = 3'd2,
    PH_CRC  = 3'd3,
    PH_EOF  = 3'd4
  } phase_t;

  typedef enum logic {
    KIND_PAYLOAD = 1'b0,
    KIND_FINISH  = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] end_byte;
    logic [7:0] payload_limit;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] opcode;
    logic [7:0] payload_byte;
    logic [6:0] byte_index;
    logic [7:0] payload_count;
    status_t    status;
  } result_t;

endpackage

@@ rtl/sofd_cfg_regs.sv @@
module sofd_cfg_regs (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                wr_en,
  input  logic [1:0]          wr_index,
  input  logic [7:0]          wr_data,
  output sofd_pkg::cfg_t      cfg
);
  import sofd_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_byte    <= START_BYTE_RST;
      cfg_r.end_byte      <= END_BYTE_RST;
      cfg_r.payload_limit <= PAYLOAD_LIMIT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_START_BYTE:    cfg_r.start_byte    <= wr_data;
        REG_END_BYTE:      cfg_r.end_byte      <= wr_data;
        REG_PAYLOAD_LIMIT: cfg_r.payload_limit <= wr_data;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/sofd_parser.sv @@
module sofd_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_en,
  input  logic [7:0]          rx_byte,
  input  sofd_pkg::cfg_t      cfg,
  output logic                res_valid,
  output sofd_pkg::result_t   res
);
  import sofd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] frame_opcode_r, frame_opcode_nxt;
  logic [7:0] bytes_seen_r, bytes_seen_nxt;
  logic [7:0] running_xor_r, running_xor_nxt;

  logic [7:0] limit;
  logic [7:0] seen_inc;
  logic [7:0] idx_full;
  logic [7:0] count_full;

  assign limit      = (cfg.payload_limit > MAX_PAYLOAD_B) ? MAX_PAYLOAD_B : cfg.payload_limit;
  assign seen_inc   = bytes_seen_r + 8'd1;
  assign idx_full   = bytes_seen_r - 8'd1;
  assign count_full = frame_length_r - 8'd1;

  always_comb begin
    phase_nxt        = phase_r;
    frame_length_nxt = frame_length_r;
    frame_opcode_nxt = frame_opcode_r;
    bytes_seen_nxt   = bytes_seen_r;
    running_xor_nxt  = running_xor_r;
    res_valid        = 1'b0;
    res              = '0;

    unique case (phase_r)
      PH_IDLE: begin
        if (rx_byte == cfg.start_byte) begin
          phase_nxt      = PH_LEN;
          bytes_seen_nxt = '0;
        end
      end
      PH_LEN: begin
        bytes_seen_nxt = '0;
        if (rx_byte == 8'd0 || {1'b0, rx_byte} > ({1'b0, limit} + 9'd1)) begin
          phase_nxt        = PH_IDLE;
          frame_length_nxt = '0;
          res_valid        = 1'b1;
          res.kind         = KIND_FINISH;
          res.status       = ST_LEN_BAD;
        end else begin
          frame_length_nxt = rx_byte;
          running_xor_nxt  = rx_byte;
          phase_nxt        = PH_BODY;
        end
      end
      PH_BODY: begin
        running_xor_nxt = running_xor_r ^ rx_byte;
        if (bytes_seen_r == 8'd0) begin
          frame_opcode_nxt = rx_byte;
        end else begin
          res_valid        = 1'b1;
          res.kind         = KIND_PAYLOAD;
          res.opcode       = frame_opcode_r;
          res.payload_byte = rx_byte;
          res.byte_index   = idx_full[6:0];
        end
        bytes_seen_nxt = seen_inc;
        if (seen_inc >= frame_length_r) begin
          phase_nxt = PH_CRC;
        end
      end
      PH_CRC: begin
        if (rx_byte == running_xor_r) begin
          phase_nxt = PH_EOF;
        end else begin
          phase_nxt         = PH_IDLE;
          res_valid         = 1'b1;
          res.kind          = KIND_FINISH;
          res.opcode        = frame_opcode_r;
          res.payload_count = count_full;
          res.status        = ST_XOR_BAD;
        end
      end
      PH_EOF: begin
        phase_nxt         = PH_IDLE;
        res_valid         = 1'b1;
        res.kind          = KIND_FINISH;
        res.opcode        = frame_opcode_r;
        res.payload_count = count_full;
        res.status        = (rx_byte == cfg.end_byte) ? ST_GOOD : ST_END_BAD;
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase

    if (!byte_en) begin
      res_valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      frame_length_r <= '0;
      frame_opcode_r <= '0;
      bytes_seen_r   <= '0;
      running_xor_r  <= '0;
    end else if (byte_en) begin
      phase_r        <= phase_nxt;
      frame_length_r <= frame_length_nxt;
      frame_opcode_r <= frame_opcode_nxt;
      bytes_seen_r   <= bytes_seen_nxt;
      running_xor_r  <= running_xor_nxt;
    end
  end

endmodule

@@ rtl/sofd_out_buf.sv @@
module sofd_out_buf (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sofd_pkg::result_t   push_data,
  output logic                can_push,
  output logic                out_valid,
  input  logic                out_ready,
  output sofd_pkg::result_t   out_data
);
  import sofd_pkg::*;

  logic    main_valid_r;
  logic    skid_valid_r;
  result_t main_r;
  result_t skid_r;
  logic    pop;

  assign pop = main_valid_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (main_valid_r && !pop) begin
        if (push) begin
          skid_valid_r <= 1'b1;
        end
      end else if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= push;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (main_valid_r && !pop) begin
      if (push) begin
        skid_r <= push_data;
      end
    end else if (skid_valid_r) begin
      main_r <= skid_r;
    end else if (push) begin
      main_r <= push_data;
    end
  end

  assign can_push  = ~skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_r;

endmodule

@@ rtl/sof_len_xor_eof_deframer_unit.sv @@
// Start/length/XOR/end frame parser for a received byte stream.
// in_*  : one received byte per transaction, in_tdata[7:0].
// cfg_* : register writes, index 0 start byte, 1 end byte, 2 payload limit;
//         cfg_ready is always high, write only while the block is idle.
// out_* : one result per payload byte (tuser 0) or per finished frame
//         (tuser 1, with status). Opcode bytes, a good checksum byte and
//         bytes outside a frame give no result.
// A result is registered in the output stage before it shows on out_tvalid.
// Throughput: one byte per cycle while in_tready is high; the phase machine
// and running XOR finish each byte in the cycle it is taken.
// A two-deep output stage (result register plus skid) lets the next byte in
// while a result waits; in_tready drops only when both are full, which
// happens after the receiver holds out_tready low.
// Reset (rst_n low, synchronous) returns the parser to hunting for the start
// byte, restores register defaults and drops all pending results.
module sof_len_xor_eof_deframer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,     // [7:0] rx_byte
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [sofd_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [7:0] opcode, [15:8] payload_byte, [22:16] byte_index,
  // [30:23] payload_count, [32:31] status, [39:33] zero
  output logic        out_tuser     // [0] kind
);
  import sofd_pkg::*;

  cfg_t    cfg;
  logic    byte_en;
  logic    res_valid;
  result_t res;
  logic    can_push;
  result_t out_res;

  assign cfg_ready = 1'b1;
  assign in_tready = can_push;
  assign byte_en   = in_tvalid & can_push;

  sofd_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  sofd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .rx_byte   (in_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  sofd_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .can_push  (can_push),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_res)
  );

  assign out_tuser = out_res.kind;
  assign out_tdata = {7'd0, out_res.status, out_res.payload_count, out_res.byte_index,
                      out_res.payload_byte, out_res.opcode};

endmodule

@@ rtl/sofd_checker.sv @@
`include "sof_len_xor_eof_deframer_unit_defines.svh"

module sofd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser
);
  import sofd_pkg::*;

  `SOFD_ASSERT_RST(a_no_out_after_reset, !rst_n |=> !out_tvalid, "result valid after reset")

  `SOFD_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid, "result dropped while stalled")

  `SOFD_ASSERT(a_payload_clean, out_tvalid && !out_tuser |-> out_tdata[32:23] == 10'd0, "payload transaction carries status or count")

  `SOFD_ASSERT(a_finish_clean, out_tvalid && out_tuser |-> out_tdata[22:8] == 15'd0, "finish transaction carries payload byte or index")

  `SOFD_ASSERT(a_len_bad_clean, out_tvalid && out_tuser && out_tdata[32:31] == ST_LEN_BAD |-> out_tdata[7:0] == 8'd0 && out_tdata[30:23] == 8'd0, "length error with opcode or count")

endmodule

bind sof_len_xor_eof_deframer_unit sofd_checker u_sofd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

@@ bench/tb_sof_len_xor_eof_deframer_unit.sv @@
module tb_sof_len_xor_eof_deframer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import sofd_pkg::*;

  localparam int unsigned RANDOM_BYTES = 1150;
  localparam int unsigned QUIET_LIMIT  = 5000;

  typedef enum int {
    FR_GOOD,
    FR_BAD_XOR,
    FR_BAD_END
  } frame_fault_t;

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [7:0]             in_tdata;     // [7:0] rx_byte
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [1:0]             cfg_index;
  logic [7:0]             cfg_data;
  logic                   out_tvalid;
  logic                   out_tready;
  // [7:0] opcode, [15:8] payload_byte, [22:16] byte_index,
  // [30:23] payload_count, [32:31] status, [39:33] zero
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;    // [0] kind

  // register shadows
  logic [7:0] sof_value;
  logic [7:0] eof_value;
  logic [7:0] limit_value;

  // parser state
  phase_t     rx_phase;
  logic [7:0] frame_size;
  logic [7:0] frame_op;
  logic [7:0] body_count;
  logic [7:0] xor_acc;

  result_t     pending_results[$];
  int unsigned err_count;
  int unsigned bytes_sent;
  int unsigned results_seen;
  int unsigned frames_sent;
  int unsigned settings_used;
  int unsigned quiet_cycles;
  bit          in_idling;
  bit          out_idling;

  sof_len_xor_eof_deframer_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic int unsigned effective_limit();
    return (limit_value > MAX_PAYLOAD) ? MAX_PAYLOAD : limit_value;
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    result_t r;
    r = '0;
    case (rx_phase)
      PH_IDLE: begin
        if (b == sof_value) begin
          rx_phase   = PH_LEN;
          body_count = 8'd0;
        end
      end
      PH_LEN: begin
        body_count = 8'd0;
        if (b == 8'd0 || b > effective_limit() + 1) begin
          rx_phase   = PH_IDLE;
          frame_size = 8'd0;
          r.kind     = KIND_FINISH;
          r.status   = ST_LEN_BAD;
          pending_results.push_back(r);
        end else begin
          frame_size = b;
          xor_acc    = b;
          rx_phase   = PH_BODY;
        end
      end
      PH_BODY: begin
        xor_acc = xor_acc ^ b;
        if (body_count == 8'd0) begin
          frame_op = b;
        end else begin
          r.kind         = KIND_PAYLOAD;
          r.opcode       = frame_op;
          r.payload_byte = b;
          r.byte_index   = 7'(body_count - 8'd1);
          r.status       = ST_GOOD;
          pending_results.push_back(r);
        end
        body_count = body_count + 8'd1;
        if (body_count >= frame_size) rx_phase = PH_CRC;
      end
      PH_CRC: begin
        if (b == xor_acc) begin
          rx_phase = PH_EOF;
        end else begin
          rx_phase        = PH_IDLE;
          r.kind          = KIND_FINISH;
          r.opcode        = frame_op;
          r.payload_count = frame_size - 8'd1;
          r.status        = ST_XOR_BAD;
          pending_results.push_back(r);
        end
      end
      PH_EOF: begin
        rx_phase        = PH_IDLE;
        r.kind          = KIND_FINISH;
        r.opcode        = frame_op;
        r.payload_count = frame_size - 8'd1;
        r.status        = (b == eof_value) ? ST_GOOD : ST_END_BAD;
        pending_results.push_back(r);
      end
      default: rx_phase = PH_IDLE;
    endcase
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $error("result with nothing expected: tuser %0b tdata %h", out_tuser, out_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        check_field("kind", want.kind, out_tuser);
        check_field("opcode", want.opcode, out_tdata[7:0]);
        check_field("payload_byte", want.payload_byte, out_tdata[15:8]);
        check_field("byte_index", want.byte_index, out_tdata[22:16]);
        check_field("payload_count", want.payload_count, out_tdata[30:23]);
        check_field("status", want.status, out_tdata[32:31]);
        check_field("pad", 0, out_tdata[39:33]);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_sof_len_xor_eof_deframer_unit: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : result_sink
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (out_idling && $urandom_range(0, 6) == 0) begin
        hold = $urandom_range(1, 17);
        out_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // leaves in_tvalid high so back-to-back bytes stream without a bubble when no idle gap is drawn
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    if (in_idling && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 17);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    parse_byte(b);
    bytes_sent++;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // leaves cfg_valid high; the caller drops it after the last write
  task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_START_BYTE:    sof_value = v;
      REG_END_BYTE:      eof_value = v;
      REG_PAYLOAD_LIMIT: limit_value = v;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] sof, input logic [7:0] eof,
                           input logic [7:0] lim);
    wait_idle();
    write_reg(REG_START_BYTE, sof);
    write_reg(REG_END_BYTE, eof);
    write_reg(REG_PAYLOAD_LIMIT, lim);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  task automatic send_frame(input logic [7:0] len, input logic [7:0] op,
                            input frame_fault_t fault);
    logic [7:0] sum;
    logic [7:0] b;
    frames_sent++;
    send_byte(sof_value);
    send_byte(len);
    send_byte(op);
    sum = len ^ op;
    for (int i = 1; i < len; i++) begin
      b   = 8'($urandom_range(0, 255));
      sum = sum ^ b;
      send_byte(b);
    end
    if (fault == FR_BAD_XOR) sum = sum ^ 8'($urandom_range(1, 255));
    send_byte(sum);
    if (fault == FR_BAD_END) send_byte(eof_value ^ 8'($urandom_range(1, 255)));
    else send_byte(eof_value);
  endtask

  task automatic test_frame_shapes();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(8'd1, 8'h5A, FR_GOOD);
    // payload with both byte extremes and the start byte inside the frame
    send_byte(sof_value);
    send_byte(8'd4);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(sof_value);
    send_byte(8'd4 ^ 8'hFF ^ 8'h00 ^ 8'hFF ^ sof_value);
    send_byte(eof_value);
    send_frame(8'd3, 8'h81, FR_BAD_XOR);
    send_frame(8'd2, 8'h7E, FR_BAD_END);
    send_byte(sof_value);
    send_byte(8'd0);
    send_byte(sof_value);
    send_byte(8'd130);
  endtask

  task automatic test_limits();
    configure(8'h00, 8'hFF, 8'd0);
    send_frame(8'd1, 8'hC3, FR_GOOD);
    send_byte(sof_value);
    send_byte(8'd2);
    // limit above the maximum saturates
    configure(8'hFF, 8'h00, 8'd255);
    send_byte(sof_value);
    send_byte(8'd130);
    send_frame(8'd4, 8'h3C, FR_GOOD);
    // limit written between start byte and length byte
    configure(8'hAA, 8'h55, 8'd128);
    send_byte(sof_value);
    configure(8'hAA, 8'h55, 8'd2);
    send_byte(8'd5);
    send_frame(8'd3, 8'h11, FR_GOOD);
  endtask

  task automatic test_random();
    int unsigned start_count;
    int unsigned phase_start;
    int unsigned setting_no;
    int unsigned pick;
    int unsigned lim;
    logic [7:0]  lim_pick;
    frame_fault_t fault;
    bit          paused;
    start_count = bytes_sent;
    setting_no  = 0;
    paused      = 1'b0;
    while (bytes_sent - start_count < RANDOM_BYTES) begin
      case (setting_no % 6)
        0: lim_pick = 8'd128;
        1: lim_pick = 8'd0;
        2: lim_pick = 8'd255;
        3: lim_pick = 8'd1;
        4: lim_pick = 8'd16;
        default: lim_pick = 8'($urandom_range(0, 255));
      endcase
      configure(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), lim_pick);
      if (RANDOM_BYTES - (bytes_sent - start_count) < 250) begin
        in_idling  = 1'b0;
        out_idling = 1'b0;
      end else begin
        in_idling  = (setting_no % 3) != 2;
        out_idling = (setting_no % 4) != 3;
      end
      setting_no++;
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < 150) begin
        if (!paused && bytes_sent - start_count > RANDOM_BYTES / 2) begin
          wait_idle();
          paused = 1'b1;
        end
        lim  = effective_limit();
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
          send_byte(8'($urandom_range(0, 255)));
        end else if (pick < 10) begin
          send_byte(sof_value);
          if ($urandom_range(0, 1) == 0) send_byte(8'd0);
          else send_byte(8'($urandom_range(lim + 2, 255)));
        end else begin
          pick = $urandom_range(0, 9);
          fault = (pick == 0) ? FR_BAD_XOR : (pick == 1) ? FR_BAD_END : FR_GOOD;
          if ($urandom_range(0, 59) == 0) begin
            send_frame(8'(lim + 1), 8'($urandom_range(0, 255)), fault);
          end else begin
            send_frame(8'($urandom_range(1, (lim + 1 < 8) ? lim + 1 : 8)),
                       8'($urandom_range(0, 255)), fault);
          end
        end
      end
    end
  endtask

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = 8'h00;
    cfg_valid   = 1'b0;
    cfg_index   = REG_START_BYTE;
    cfg_data    = 8'h00;
    out_tready  = 1'b0;
    sof_value   = START_BYTE_RST;
    eof_value   = END_BYTE_RST;
    limit_value = PAYLOAD_LIMIT_RST;
    rx_phase    = PH_IDLE;
    frame_size  = 8'd0;
    frame_op    = 8'd0;
    body_count  = 8'd0;
    xor_acc     = 8'd0;
    in_idling   = 1'b1;
    out_idling  = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    test_frame_shapes();
    test_limits();
    test_random();
    wait_idle();
    repeat (10) @(posedge clk);
    $display("covered %0d bytes, %0d frames, %0d results over %0d register settings",
             bytes_sent, frames_sent, results_seen, settings_used);
    $display("including length, checksum and end-byte faults and limit saturation");
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("tb_sof_len_xor_eof_deframer_unit: clean");
    end else begin
      $display("tb_sof_len_xor_eof_deframer_unit: errors");
    end
    $finish;
  end

endmodule
